// ===== sv/psd_pkg.sv =====
// shared widths, beat types and region codes for the point to segment distance block
package psd_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = 2 * COORD_W + 2;
    localparam int DOT_W   = SUM_W + 1;
    localparam int HALF_W  = SUM_W / 2;
    localparam int CR2_W   = 2 * SUM_W;
    localparam int QUO_W   = SUM_W;
    localparam int DREM_W  = SUM_W + 1;
    localparam int DIST_W  = COORD_W + 1;
    localparam int SREM_W  = DIST_W + 3;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        region_t           region;
    } out_beat_t;

    typedef struct packed {
        logic             interior;
        region_t          region;
        logic [QUO_W-1:0] endq;
    } side_t;

endpackage

// ===== sv/point_segment_distance.sv =====
// top level: point to segment distance pipeline with output register
//
//  channel  direction  beat type   meaning
//  s_       in         in_beat_t   query point and segment endpoints
//  m_       out        out_beat_t  distance and region code
//
// one beat per cycle sustained while the output is not stalled; depth at 32-bit coordinates:
// 6 geometry stages, 66 divider stages, 33 square root stages, 1 output register
// the divider bit count sets the depth
// a stalled output freezes the pipeline only when its last stage holds a beat
// reset clears all valid bits; no clearing pass
module point_segment_distance (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  psd_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output psd_pkg::out_beat_t   m_data
);
    import psd_pkg::*;

    logic             adv;
    logic             g_valid;
    logic [CR2_W-1:0] g_cr2;
    logic [SUM_W-1:0] g_len2;
    side_t            g_side;
    logic             d_valid;
    logic [QUO_W-1:0] d_quo;
    side_t            d_side;
    logic [SUM_W-1:0] q_sel;
    logic             sq_valid;
    logic [DIST_W-1:0] sq_root;
    region_t          sq_region;
    logic             m_valid_reg;
    out_beat_t        m_data_reg;

    assign adv     = !m_valid_reg || m_ready || !sq_valid;
    assign s_ready = adv;

    psd_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (g_valid),
        .out_cr2   (g_cr2),
        .out_len2  (g_len2),
        .out_side  (g_side)
    );

    psd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (g_valid),
        .in_num    (g_cr2),
        .in_den    (g_len2),
        .in_side   (g_side),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    assign q_sel = d_side.interior ? d_quo : d_side.endq;

    psd_sqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (d_valid),
        .in_x       (q_sel),
        .in_region  (d_side.region),
        .out_valid  (sq_valid),
        .out_root   (sq_root),
        .out_region (sq_region)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg.distance <= sq_root;
            m_data_reg.region   <= sq_region;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid && m_valid_reg && !m_ready |-> !s_ready)
        else $error("pipeline advanced into a held output");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== sv/psd_geom.sv =====
// differences, products, sums, region decision and squared cross product
module psd_geom (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  psd_pkg::in_beat_t            in_data,
    output logic                         out_valid,
    output logic [psd_pkg::CR2_W-1:0]    out_cr2,
    output logic [psd_pkg::SUM_W-1:0]    out_len2,
    output psd_pkg::side_t               out_side
);
    import psd_pkg::*;

    logic [5:0] v_reg;

    // stage 1: coordinate differences
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] pdx_reg, pdy_reg, pex_reg, pey_reg, pax_reg, pay_reg;
    logic signed [PROD_W-1:0] pbx_reg, pby_reg, pc1_reg, pc2_reg;
    // stage 3: sums
    logic signed [DOT_W-1:0] dot_reg, cross_reg;
    logic [SUM_W-1:0] len2_reg, d1_reg, d2_reg;
    // stage 4: decision
    logic [SUM_W-1:0] cmag_reg, len2_4_reg;
    side_t side4_reg;
    // stage 5: partial products
    logic [SUM_W-1:0] phh_reg, phl_reg, pll_reg, len2_5_reg;
    side_t side5_reg;
    // stage 6: squared cross product
    logic [CR2_W-1:0] cr2_reg;
    logic [SUM_W-1:0] len2_6_reg;
    side_t side6_reg;

    logic signed [DOT_W-1:0] len2_w, d1_w, d2_w;
    logic signed [DOT_W-1:0] cmag_w;
    logic [SUM_W-1:0] cmag_next;
    side_t side4_next;
    logic zero_w, inside_w;

    always_comb begin
        len2_w = DOT_W'(pex_reg) + DOT_W'(pey_reg);
        d1_w   = DOT_W'(pax_reg) + DOT_W'(pay_reg);
        d2_w   = DOT_W'(pbx_reg) + DOT_W'(pby_reg);
        cmag_w = cross_reg[DOT_W-1] ? -cross_reg : cross_reg;
        cmag_next = cmag_w[SUM_W-1:0];
        zero_w   = (len2_reg == '0);
        inside_w = !dot_reg[DOT_W-1] && (dot_reg[SUM_W-1:0] <= len2_reg);
        side4_next.interior = !zero_w && inside_w;
        if (zero_w) begin
            side4_next.region = REGION_START;
        end else if (inside_w) begin
            side4_next.region = REGION_INTERIOR;
        end else if (d1_reg < d2_reg) begin
            side4_next.region = REGION_START;
        end else begin
            side4_next.region = REGION_END;
        end
        side4_next.endq = (side4_next.region == REGION_END) ? d2_reg : d1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= $signed({in_data.point_x[COORD_W-1], in_data.point_x})
                    - $signed({in_data.start_x[COORD_W-1], in_data.start_x});
            dy_reg <= $signed({in_data.point_y[COORD_W-1], in_data.point_y})
                    - $signed({in_data.start_y[COORD_W-1], in_data.start_y});
            ex_reg <= $signed({in_data.end_x[COORD_W-1], in_data.end_x})
                    - $signed({in_data.start_x[COORD_W-1], in_data.start_x});
            ey_reg <= $signed({in_data.end_y[COORD_W-1], in_data.end_y})
                    - $signed({in_data.start_y[COORD_W-1], in_data.start_y});
            fx_reg <= $signed({in_data.point_x[COORD_W-1], in_data.point_x})
                    - $signed({in_data.end_x[COORD_W-1], in_data.end_x});
            fy_reg <= $signed({in_data.point_y[COORD_W-1], in_data.point_y})
                    - $signed({in_data.end_y[COORD_W-1], in_data.end_y});

            pdx_reg <= dx_reg * ex_reg;
            pdy_reg <= dy_reg * ey_reg;
            pex_reg <= ex_reg * ex_reg;
            pey_reg <= ey_reg * ey_reg;
            pax_reg <= dx_reg * dx_reg;
            pay_reg <= dy_reg * dy_reg;
            pbx_reg <= fx_reg * fx_reg;
            pby_reg <= fy_reg * fy_reg;
            pc1_reg <= dx_reg * ey_reg;
            pc2_reg <= dy_reg * ex_reg;

            dot_reg   <= DOT_W'(pdx_reg) + DOT_W'(pdy_reg);
            cross_reg <= DOT_W'(pc1_reg) - DOT_W'(pc2_reg);
            len2_reg  <= len2_w[SUM_W-1:0];
            d1_reg    <= d1_w[SUM_W-1:0];
            d2_reg    <= d2_w[SUM_W-1:0];

            cmag_reg   <= cmag_next;
            len2_4_reg <= len2_reg;
            side4_reg  <= side4_next;

            phh_reg    <= cmag_reg[SUM_W-1:HALF_W] * cmag_reg[SUM_W-1:HALF_W];
            phl_reg    <= cmag_reg[SUM_W-1:HALF_W] * cmag_reg[HALF_W-1:0];
            pll_reg    <= cmag_reg[HALF_W-1:0] * cmag_reg[HALF_W-1:0];
            len2_5_reg <= len2_4_reg;
            side5_reg  <= side4_reg;

            cr2_reg <= (CR2_W'(phh_reg) << SUM_W) + (CR2_W'(phl_reg) << (HALF_W + 1))
                     + CR2_W'(pll_reg);
            len2_6_reg <= len2_5_reg;
            side6_reg  <= side5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign out_cr2   = cr2_reg;
    assign out_len2  = len2_6_reg;
    assign out_side  = side6_reg;

endmodule

// ===== sv/psd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module psd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [psd_pkg::CR2_W-1:0]    in_num,
    input  logic [psd_pkg::SUM_W-1:0]    in_den,
    input  psd_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [psd_pkg::QUO_W-1:0]    out_quo,
    output psd_pkg::side_t               out_side
);
    import psd_pkg::*;

    logic              v_reg    [QUO_W];
    logic [DREM_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0]  num_reg  [QUO_W];
    logic [SUM_W-1:0]  den_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    side_t             side_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic              v_in;
        logic [DREM_W-1:0] rem_in;
        logic [QUO_W-1:0]  num_in;
        logic [SUM_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        side_t             side_in;
        logic [DREM_W-1:0] trial;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = DREM_W'(in_num[CR2_W-1:QUO_W]);
            assign num_in  = in_num[QUO_W-1:0];
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign num_in  = num_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign trial = {rem_in[DREM_W-2:0], num_in[QUO_W-1-s]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s]  <= ge ? trial - {1'b0, den_in} : trial;
                num_reg[s]  <= num_in;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= quo_in | (ge ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== sv/psd_sqrt.sv =====
// pipelined digit by digit integer square root, one root bit per stage
module psd_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [psd_pkg::SUM_W-1:0]    in_x,
    input  psd_pkg::region_t             in_region,
    output logic                         out_valid,
    output logic [psd_pkg::DIST_W-1:0]   out_root,
    output psd_pkg::region_t             out_region
);
    import psd_pkg::*;

    logic              v_reg    [DIST_W];
    logic [SREM_W-1:0] rem_reg  [DIST_W];
    logic [DIST_W-1:0] root_reg [DIST_W];
    logic [SUM_W-1:0]  x_reg    [DIST_W];
    region_t           reg_reg  [DIST_W];

    for (genvar s = 0; s < DIST_W; s++) begin : g_stage
        logic              v_in;
        logic [SREM_W-1:0] rem_in;
        logic [DIST_W-1:0] root_in;
        logic [SUM_W-1:0]  x_in;
        region_t           region_in;
        logic [SREM_W-1:0] trial;
        logic [SREM_W-1:0] sub;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_in      = in_valid;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign x_in      = in_x;
            assign region_in = in_region;
        end else begin : g_next
            assign v_in      = v_reg[s-1];
            assign rem_in    = rem_reg[s-1];
            assign root_in   = root_reg[s-1];
            assign x_in      = x_reg[s-1];
            assign region_in = reg_reg[s-1];
        end

        assign trial = {rem_in[SREM_W-3:0], x_in[2*(DIST_W-1-s)+1 -: 2]};
        assign sub   = SREM_W'({root_in, 2'b01});
        assign ge    = (trial >= sub);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s]  <= ge ? trial - sub : trial;
                root_reg[s] <= {root_in[DIST_W-2:0], ge};
                x_reg[s]    <= x_in;
                reg_reg[s]  <= region_in;
            end
        end
    end

    assign out_valid  = v_reg[DIST_W-1];
    assign out_root   = root_reg[DIST_W-1];
    assign out_region = reg_reg[DIST_W-1];

endmodule
